@@ sv/page_boundary_chunk_splitter_core_macros.svh @@
// ----------------------------------------------------------------------------
// page boundary chunk splitter assertion macros
// concurrent check helpers, empty when SYNTH is defined
// ----------------------------------------------------------------------------
`ifndef PAGE_BOUNDARY_CHUNK_SPLITTER_CORE_MACROS_SVH
`define PAGE_BOUNDARY_CHUNK_SPLITTER_CORE_MACROS_SVH

`ifndef SYNTH
`define PBCS_ASSERT_SAME(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("pbcs same-cycle check failed");
`define PBCS_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("pbcs next-cycle check failed");
`else
`define PBCS_ASSERT_SAME(label, ante, cons)
`define PBCS_ASSERT_NEXT(label, ante, cons)
`endif

`endif

@@ sv/pbcs_pkg.sv @@
// ----------------------------------------------------------------------------
// pbcs_pkg
// shared widths, register indexes, controller states and command/status types
// ----------------------------------------------------------------------------
package pbcs_pkg;

   localparam int DATA_WIDTH      = 32;
   localparam int CSR_INDEX_WIDTH = 2;
   localparam int DIV_COUNT_WIDTH = $clog2(DATA_WIDTH);

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_START_ADDRESS = 2'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_PAGE_SIZE     = 2'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_PACKET_SIZE   = 2'd2;

   typedef enum logic [2:0] {
      S_IDLE,
      S_DIV_CUR_GO,
      S_DIV_CUR_WAIT,
      S_DIV_CHK_GO,
      S_DIV_CHK_WAIT,
      S_EVAL,
      S_EMIT_CLOSE,
      S_EMIT_FINAL
   } state_type;

   typedef struct packed {
      logic capture;
      logic div_start;
      logic div_chunk;
      logic load_cur;
      logic load_chunk;
      logic open;
      logic emit_close;
      logic emit_final;
      logic advance;
   } cmd_type;

   typedef struct packed {
      logic div_done;
      logic page_known;
      logic dirty;
      logic close;
      logic final_byte;
      logic out_free;
   } status_type;

endpackage

@@ sv/pbcs_divider.sv @@
// ----------------------------------------------------------------------------
// pbcs_divider
// restoring divider, one quotient bit per cycle, done pulses when finished
// ----------------------------------------------------------------------------
module pbcs_divider (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  logic [pbcs_pkg::DATA_WIDTH-1:0] dividend,
   input  logic [pbcs_pkg::DATA_WIDTH-1:0] divisor,
   output logic                           done,
   output logic [pbcs_pkg::DATA_WIDTH-1:0] quotient,
   output logic [pbcs_pkg::DATA_WIDTH-1:0] remainder
);

   localparam int W = pbcs_pkg::DATA_WIDTH;
   localparam logic [pbcs_pkg::DIV_COUNT_WIDTH-1:0] LAST_STEP =
      pbcs_pkg::DIV_COUNT_WIDTH'(W - 1);

   logic                                busy_ff, busy_in;
   logic                                done_ff, done_in;
   logic [pbcs_pkg::DIV_COUNT_WIDTH-1:0] count_ff, count_in;
   logic [W-1:0]                        quo_ff, quo_in;
   logic [W-1:0]                        rem_ff, rem_in;
   logic [W-1:0]                        div_ff, div_in;
   logic [W:0]                          trial;
   logic [W:0]                          diff;

   assign trial = {rem_ff, quo_ff[W-1]};
   assign diff  = trial - {1'b0, div_ff};

   always_comb begin
      busy_in  = busy_ff;
      done_in  = 1'b0;
      count_in = count_ff;
      quo_in   = quo_ff;
      rem_in   = rem_ff;
      div_in   = div_ff;
      if (start) begin
         busy_in  = 1'b1;
         count_in = '0;
         quo_in   = dividend;
         rem_in   = '0;
         div_in   = divisor;
      end else if (busy_ff) begin
         if (!diff[W]) begin
            rem_in = diff[W-1:0];
         end else begin
            rem_in = trial[W-1:0];
         end
         quo_in   = {quo_ff[W-2:0], ~diff[W]};
         count_in = count_ff + 1'b1;
         if (count_ff == LAST_STEP) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         done_ff  <= done_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      div_ff <= div_in;
   end

   assign done      = done_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff;

endmodule

@@ sv/pbcs_ctrl.sv @@
// ----------------------------------------------------------------------------
// pbcs_ctrl
// controller: sequences page lookup, chunk decision and item emission
// ----------------------------------------------------------------------------
module pbcs_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  pbcs_pkg::status_type status,
   output pbcs_pkg::cmd_type    cmd
);

   pbcs_pkg::state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         pbcs_pkg::S_IDLE: begin
            if (req_valid) begin
               state_in = status.dirty ? pbcs_pkg::S_DIV_CUR_GO : pbcs_pkg::S_EVAL;
            end
         end
         pbcs_pkg::S_DIV_CUR_GO: begin
            state_in = pbcs_pkg::S_DIV_CUR_WAIT;
         end
         pbcs_pkg::S_DIV_CUR_WAIT: begin
            if (status.div_done) begin
               state_in = status.page_known ? pbcs_pkg::S_DIV_CHK_GO : pbcs_pkg::S_EVAL;
            end
         end
         pbcs_pkg::S_DIV_CHK_GO: begin
            state_in = pbcs_pkg::S_DIV_CHK_WAIT;
         end
         pbcs_pkg::S_DIV_CHK_WAIT: begin
            if (status.div_done) begin
               state_in = pbcs_pkg::S_EVAL;
            end
         end
         pbcs_pkg::S_EVAL: begin
            if (status.close) begin
               state_in = pbcs_pkg::S_EMIT_CLOSE;
            end else if (status.final_byte) begin
               state_in = pbcs_pkg::S_EMIT_FINAL;
            end else begin
               state_in = pbcs_pkg::S_IDLE;
            end
         end
         pbcs_pkg::S_EMIT_CLOSE: begin
            if (status.out_free) begin
               state_in = status.final_byte ? pbcs_pkg::S_EMIT_FINAL : pbcs_pkg::S_IDLE;
            end
         end
         pbcs_pkg::S_EMIT_FINAL: begin
            if (status.out_free) begin
               state_in = pbcs_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = pbcs_pkg::S_IDLE;
         end
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_stall = 1'b1;
      case (state_ff)
         pbcs_pkg::S_IDLE: begin
            req_stall   = 1'b0;
            cmd.capture = req_valid;
         end
         pbcs_pkg::S_DIV_CUR_GO: begin
            cmd.div_start = 1'b1;
         end
         pbcs_pkg::S_DIV_CUR_WAIT: begin
            cmd.load_cur = status.div_done;
         end
         pbcs_pkg::S_DIV_CHK_GO: begin
            cmd.div_start = 1'b1;
            cmd.div_chunk = 1'b1;
         end
         pbcs_pkg::S_DIV_CHK_WAIT: begin
            cmd.load_chunk = status.div_done;
         end
         pbcs_pkg::S_EVAL: begin
            cmd.open    = ~status.page_known;
            cmd.advance = ~status.close & ~status.final_byte;
         end
         pbcs_pkg::S_EMIT_CLOSE: begin
            cmd.emit_close = status.out_free;
            cmd.advance    = status.out_free & ~status.final_byte;
         end
         pbcs_pkg::S_EMIT_FINAL: begin
            cmd.emit_final = status.out_free;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= pbcs_pkg::S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

@@ sv/pbcs_datapath.sv @@
// ----------------------------------------------------------------------------
// pbcs_datapath
// config registers, blob and page tracking, chunk decision and output register
// ----------------------------------------------------------------------------
module pbcs_datapath (
   input  logic                                  clock,
   input  logic                                  reset,
   input  pbcs_pkg::cmd_type                     cmd,
   output pbcs_pkg::status_type                  status,
   input  logic                                  csr_write,
   input  logic [pbcs_pkg::CSR_INDEX_WIDTH-1:0]  csr_index,
   input  logic [pbcs_pkg::DATA_WIDTH-1:0]       csr_data,
   input  logic                                  req_final_byte,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic [pbcs_pkg::DATA_WIDTH-1:0]       rsp_chunk_number,
   output logic [pbcs_pkg::DATA_WIDTH-1:0]       rsp_chunk_page,
   output logic [pbcs_pkg::DATA_WIDTH-1:0]       rsp_page_address,
   output logic [pbcs_pkg::DATA_WIDTH-1:0]       rsp_blob_offset,
   output logic [pbcs_pkg::DATA_WIDTH-1:0]       rsp_chunk_length,
   output logic                                  rsp_last_chunk
);

   localparam int W = pbcs_pkg::DATA_WIDTH;

   logic [W-1:0] start_address_ff, start_address_in;
   logic [W-1:0] page_size_ff, page_size_in;
   logic [W-1:0] packet_size_ff, packet_size_in;
   logic [W-1:0] byte_pos_ff, byte_pos_in;
   logic [W-1:0] chunk_start_ff, chunk_start_in;
   logic [W-1:0] open_page_ff, open_page_in;
   logic [W-1:0] chunks_ff, chunks_in;
   logic         page_known_ff, page_known_in;
   logic         dirty_ff, dirty_in;
   logic         final_ff, final_in;
   logic         rsp_valid_ff, rsp_valid_in;
   logic [W-1:0] cur_addr_ff, cur_addr_in;
   logic [W-1:0] cur_page_ff, cur_page_in;
   logic [W-1:0] cur_rem_ff, cur_rem_in;
   logic [W-1:0] chunk_rem_ff, chunk_rem_in;
   logic [W-1:0] num_ff, num_in;
   logic [W-1:0] page_ff, page_in;
   logic [W-1:0] addr_ff, addr_in;
   logic [W-1:0] offset_ff, offset_in;
   logic [W-1:0] length_ff, length_in;
   logic         last_ff, last_in;

   logic [W-1:0] div_dividend;
   logic         div_done;
   logic [W-1:0] div_quotient;
   logic [W-1:0] div_remainder;
   logic [W-1:0] cur_len;
   logic [W-1:0] addr_next;
   logic [W-1:0] rem_next;
   logic         out_free;

   assign div_dividend = start_address_ff + (cmd.div_chunk ? chunk_start_ff : byte_pos_ff);

   pbcs_divider u_divider (
      .clock     (clock),
      .reset     (reset),
      .start     (cmd.div_start),
      .dividend  (div_dividend),
      .divisor   (page_size_ff),
      .done      (div_done),
      .quotient  (div_quotient),
      .remainder (div_remainder)
   );

   assign cur_len   = byte_pos_ff - chunk_start_ff;
   assign addr_next = cur_addr_ff + 1'b1;
   assign rem_next  = cur_rem_ff + 1'b1;
   assign out_free  = ~rsp_valid_ff | ~rsp_stall;

   always_comb begin
      status.div_done   = div_done;
      status.page_known = page_known_ff;
      status.dirty      = dirty_ff;
      status.close      = page_known_ff & ((cur_page_ff != open_page_ff) |
                          ((packet_size_ff != '0) & (cur_len >= packet_size_ff)));
      status.final_byte = final_ff;
      status.out_free   = out_free;
   end

   always_comb begin
      start_address_in = start_address_ff;
      page_size_in     = page_size_ff;
      packet_size_in   = packet_size_ff;
      byte_pos_in      = byte_pos_ff;
      chunk_start_in   = chunk_start_ff;
      open_page_in     = open_page_ff;
      chunks_in        = chunks_ff;
      page_known_in    = page_known_ff;
      dirty_in         = dirty_ff;
      final_in         = final_ff;
      rsp_valid_in     = rsp_valid_ff & rsp_stall;
      cur_addr_in      = cur_addr_ff;
      cur_page_in      = cur_page_ff;
      cur_rem_in       = cur_rem_ff;
      chunk_rem_in     = chunk_rem_ff;
      num_in           = num_ff;
      page_in          = page_ff;
      addr_in          = addr_ff;
      offset_in        = offset_ff;
      length_in        = length_ff;
      last_in          = last_ff;

      if (csr_write) begin
         dirty_in = 1'b1;
         case (csr_index)
            pbcs_pkg::CSR_START_ADDRESS: start_address_in = csr_data;
            pbcs_pkg::CSR_PAGE_SIZE:     page_size_in     = csr_data;
            pbcs_pkg::CSR_PACKET_SIZE:   packet_size_in   = csr_data;
            default:                     dirty_in         = 1'b1;
         endcase
      end

      if (cmd.capture) begin
         final_in = req_final_byte;
      end

      // page of the current byte, from a fresh division
      if (cmd.div_start && !cmd.div_chunk) begin
         cur_addr_in = div_dividend;
      end
      if (cmd.load_cur) begin
         cur_page_in = (page_size_ff == '0) ? '0 : div_quotient;
         cur_rem_in  = div_remainder;
         dirty_in    = 1'b0;
      end
      if (cmd.load_chunk) begin
         chunk_rem_in = div_remainder;
      end

      if (cmd.open) begin
         open_page_in   = cur_page_ff;
         chunk_start_in = byte_pos_ff;
         chunk_rem_in   = cur_rem_ff;
         page_known_in  = 1'b1;
      end

      // incremental page tracking for the next byte
      if (cmd.advance) begin
         byte_pos_in = byte_pos_ff + 1'b1;
         cur_addr_in = addr_next;
         if (page_size_ff == '0) begin
            cur_page_in = '0;
            cur_rem_in  = addr_next;
         end else if (addr_next == '0) begin
            cur_page_in = '0;
            cur_rem_in  = '0;
         end else if (rem_next == page_size_ff) begin
            cur_page_in = cur_page_ff + 1'b1;
            cur_rem_in  = '0;
         end else begin
            cur_rem_in = rem_next;
         end
      end

      if (cmd.emit_close) begin
         rsp_valid_in   = 1'b1;
         num_in         = chunks_ff;
         page_in        = open_page_ff;
         addr_in        = chunk_rem_ff;
         offset_in      = chunk_start_ff;
         length_in      = cur_len;
         last_in        = 1'b0;
         chunks_in      = chunks_ff + 1'b1;
         chunk_start_in = byte_pos_ff;
         open_page_in   = cur_page_ff;
         chunk_rem_in   = cur_rem_ff;
      end

      if (cmd.emit_final) begin
         rsp_valid_in   = 1'b1;
         num_in         = chunks_ff;
         page_in        = open_page_ff;
         addr_in        = chunk_rem_ff;
         offset_in      = chunk_start_ff;
         length_in      = cur_len + 1'b1;
         last_in        = 1'b1;
         byte_pos_in    = '0;
         chunk_start_in = '0;
         open_page_in   = '0;
         chunks_in      = '0;
         page_known_in  = 1'b0;
         dirty_in       = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         start_address_ff <= '0;
         page_size_ff     <= '0;
         packet_size_ff   <= '0;
         byte_pos_ff      <= '0;
         chunk_start_ff   <= '0;
         open_page_ff     <= '0;
         chunks_ff        <= '0;
         page_known_ff    <= 1'b0;
         dirty_ff         <= 1'b1;
         final_ff         <= 1'b0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         start_address_ff <= start_address_in;
         page_size_ff     <= page_size_in;
         packet_size_ff   <= packet_size_in;
         byte_pos_ff      <= byte_pos_in;
         chunk_start_ff   <= chunk_start_in;
         open_page_ff     <= open_page_in;
         chunks_ff        <= chunks_in;
         page_known_ff    <= page_known_in;
         dirty_ff         <= dirty_in;
         final_ff         <= final_in;
         rsp_valid_ff     <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_addr_ff  <= cur_addr_in;
      cur_page_ff  <= cur_page_in;
      cur_rem_ff   <= cur_rem_in;
      chunk_rem_ff <= chunk_rem_in;
      num_ff       <= num_in;
      page_ff      <= page_in;
      addr_ff      <= addr_in;
      offset_ff    <= offset_in;
      length_ff    <= length_in;
      last_ff      <= last_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_chunk_number = num_ff;
   assign rsp_chunk_page   = page_ff;
   assign rsp_page_address = addr_ff;
   assign rsp_blob_offset  = offset_ff;
   assign rsp_chunk_length = length_ff;
   assign rsp_last_chunk   = last_ff;

endmodule

@@ sv/page_boundary_chunk_splitter_core.sv @@
// an accepted byte is judged in S_EVAL; a chunk item is then loaded into the output register
// bytes are taken only in S_IDLE, one at a time; emit states wait while the output is full
// the first byte of a blob and the first byte after a csr write run the 32-step divider
//   once, twice mid-blob when the open chunk's offset is redone too
// the result register frees the controller, so the next byte is taken while a result waits
// synchronous reset clears the csrs and the blob state; the first byte then runs a division
// ----------------------------------------------------------------------------
// page_boundary_chunk_splitter_core
// cuts a byte stream into chunks bounded by device pages and packet size
// ----------------------------------------------------------------------------
`include "page_boundary_chunk_splitter_core_macros.svh"

module page_boundary_chunk_splitter_core (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_write,
   input  logic [pbcs_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [pbcs_pkg::DATA_WIDTH-1:0]      csr_data,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic                                 req_final_byte,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic [pbcs_pkg::DATA_WIDTH-1:0]      rsp_chunk_number,
   output logic [pbcs_pkg::DATA_WIDTH-1:0]      rsp_chunk_page,
   output logic [pbcs_pkg::DATA_WIDTH-1:0]      rsp_page_address,
   output logic [pbcs_pkg::DATA_WIDTH-1:0]      rsp_blob_offset,
   output logic [pbcs_pkg::DATA_WIDTH-1:0]      rsp_chunk_length,
   output logic                                 rsp_last_chunk
);

   pbcs_pkg::cmd_type    cmd;
   pbcs_pkg::status_type status;

   pbcs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   pbcs_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .csr_write        (csr_write),
      .csr_index        (csr_index),
      .csr_data         (csr_data),
      .req_final_byte   (req_final_byte),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_chunk_number (rsp_chunk_number),
      .rsp_chunk_page   (rsp_chunk_page),
      .rsp_page_address (rsp_page_address),
      .rsp_blob_offset  (rsp_blob_offset),
      .rsp_chunk_length (rsp_chunk_length),
      .rsp_last_chunk   (rsp_last_chunk)
   );

   `PBCS_ASSERT_SAME(a_emit_into_free_slot, cmd.emit_close || cmd.emit_final, status.out_free)
   `PBCS_ASSERT_NEXT(a_one_item_at_a_time, req_valid && !req_stall, req_stall)
   `PBCS_ASSERT_NEXT(a_final_clears_blob, cmd.emit_final, !status.page_known && status.dirty)

endmodule
